// File: hdl/sfjs_pkg.sv
`default_nettype none

package sfjs_pkg;

	localparam int unsigned ADDR_BYTES = 3;
	localparam int unsigned AddrW = ADDR_BYTES * 8;
	localparam int unsigned LenW = 25;
	localparam int unsigned ChunkW = 17;
	localparam int unsigned FuncW = 3;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CmdKindW = 3;
	localparam int unsigned COMPARE_BUFFER_DEF = 64;
	localparam int unsigned QDepth = 2;

	localparam logic [FuncW-1:0] FUNC_READ = 3'd0;
	localparam logic [FuncW-1:0] FUNC_WRITE = 3'd1;
	localparam logic [FuncW-1:0] FUNC_ERASE = 3'd2;
	localparam logic [FuncW-1:0] FUNC_COMPARE = 3'd3;
	localparam logic [FuncW-1:0] FUNC_DONE = 3'd4;
	localparam logic [FuncW-1:0] FUNC_CANCEL = 3'd5;

	localparam logic [CfgIdxW-1:0] CFG_FAST_MODE = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_READ_FAST = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_READ_NORMAL = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_WRITE_FAST = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_WRITE_NORMAL = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_SECTOR = 3'd5;

	localparam logic [CmdKindW-1:0] CMD_NONE = 3'd0;
	localparam logic [CmdKindW-1:0] CMD_ERASE = 3'd1;
	localparam logic [CmdKindW-1:0] CMD_READ = 3'd2;
	localparam logic [CmdKindW-1:0] CMD_WRITE = 3'd3;
	localparam logic [CmdKindW-1:0] CMD_RDSR = 3'd4;

	localparam logic [7:0] OPC_ERASE = 8'hd8;
	localparam logic [7:0] OPC_READ = 8'h03;
	localparam logic [7:0] OPC_WRITE = 8'h02;
	localparam logic [7:0] OPC_RDSR = 8'h05;

	typedef enum logic [1:0] {
		RES_PEND = 2'd0,
		RES_OK   = 2'd1,
		RES_FAIL = 2'd2,
		RES_CANC = 2'd3
	} res_t;

	typedef enum logic [2:0] {
		KIND_NONE  = 3'd0,
		KIND_READ  = 3'd1,
		KIND_WRITE = 3'd2,
		KIND_ERASE = 3'd3,
		KIND_CMP   = 3'd4
	} job_kind_t;

	typedef enum logic [2:0] {
		PH_MAIN = 3'b001,
		PH_CMD  = 3'b010,
		PH_STAT = 3'b100
	} phase_t;

	typedef enum logic [1:0] {
		CLS_NOP    = 2'd0,
		CLS_START  = 2'd1,
		CLS_DONE   = 2'd2,
		CLS_CANCEL = 2'd3
	} item_cls_t;

	typedef struct packed {
		item_cls_t cls;
		job_kind_t kind;
		logic [AddrW-1:0] start_addr;
		logic [LenW-1:0] length;
		logic [ChunkW-1:0] chunk;
		logic seq_ok;
		logic stat_busy;
		logic match;
	} q_entry_t;

endpackage

`default_nettype wire

// File: hdl/sfjs_ifs.sv
`default_nettype none

interface sfjs_req_if;
	import sfjs_pkg::*;
	logic valid;
	logic ready;
	logic [FuncW-1:0] func;
	logic [AddrW-1:0] start_addr;
	logic [LenW-1:0] length;
	logic seq_ok;
	logic [7:0] status_byte;
	logic portion_match;
	modport source (output valid, func, start_addr, length, seq_ok, status_byte,
		portion_match, input ready);
	modport sink (input valid, func, start_addr, length, seq_ok, status_byte,
		portion_match, output ready);
endinterface

interface sfjs_rsp_if;
	import sfjs_pkg::*;
	logic valid;
	logic ready;
	logic accepted;
	logic [CmdKindW-1:0] cmd_kind;
	logic [7:0] opcode;
	logic [AddrW-1:0] flash_addr;
	logic [ChunkW-1:0] xfer_len;
	logic [LenW-1:0] buffer_offset;
	logic [1:0] job_result;
	logic busy_res;
	modport source (output valid, accepted, cmd_kind, opcode, flash_addr, xfer_len,
		buffer_offset, job_result, busy_res, input ready);
	modport sink (input valid, accepted, cmd_kind, opcode, flash_addr, xfer_len,
		buffer_offset, job_result, busy_res, output ready);
endinterface

interface sfjs_cfg_if;
	import sfjs_pkg::*;
	logic valid;
	logic ready;
	logic [CfgIdxW-1:0] index;
	logic [ChunkW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/sfjs_front.sv
`default_nettype none

module sfjs_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	sfjs_req_if.sink            req,
	sfjs_cfg_if.sink            cfg,
	input  wire logic           full,
	output logic                push,
	output sfjs_pkg::q_entry_t  push_entry
);
	import sfjs_pkg::*;

	localparam logic [ChunkW-1:0] ChunkMax = ChunkW'(65536);

	logic fast_q;
	logic [ChunkW-1:0] rd_fast_q;
	logic [ChunkW-1:0] rd_norm_q;
	logic [ChunkW-1:0] wr_fast_q;
	logic [ChunkW-1:0] wr_norm_q;
	logic [ChunkW-1:0] sector_q;
	logic [ChunkW-1:0] cfg_clamped;

	function automatic logic [ChunkW-1:0] clamp_chunk(input logic [ChunkW-1:0] v);
		logic [ChunkW-1:0] r;
		if (v == '0) begin
			r = ChunkW'(1);
		end else if (v > ChunkMax) begin
			r = ChunkMax;
		end else begin
			r = v;
		end
		return r;
	endfunction

	assign cfg.ready = 1'b1;
	assign cfg_clamped = clamp_chunk(cfg.data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_q <= 1'b0;
			rd_fast_q <= ChunkW'(64);
			rd_norm_q <= ChunkW'(64);
			wr_fast_q <= ChunkW'(1);
			wr_norm_q <= ChunkW'(1);
			sector_q <= ChunkW'(4096);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_FAST_MODE:    fast_q <= cfg.data[0];
				CFG_READ_FAST:    rd_fast_q <= cfg_clamped;
				CFG_READ_NORMAL:  rd_norm_q <= cfg_clamped;
				CFG_WRITE_FAST:   wr_fast_q <= cfg_clamped;
				CFG_WRITE_NORMAL: wr_norm_q <= cfg_clamped;
				CFG_SECTOR:       sector_q <= cfg_clamped;
				default: ;
			endcase
		end
	end

	assign req.ready = !full;
	assign push = req.valid && !full;

	always_comb begin
		push_entry.cls = CLS_NOP;
		push_entry.kind = KIND_NONE;
		push_entry.start_addr = req.start_addr;
		push_entry.length = req.length;
		push_entry.chunk = fast_q ? rd_fast_q : rd_norm_q;
		push_entry.seq_ok = req.seq_ok;
		push_entry.stat_busy = req.status_byte[0];
		push_entry.match = req.portion_match;
		unique case (req.func)
			FUNC_READ: begin
				push_entry.cls = CLS_START;
				push_entry.kind = KIND_READ;
			end
			FUNC_COMPARE: begin
				push_entry.cls = CLS_START;
				push_entry.kind = KIND_CMP;
			end
			FUNC_WRITE: begin
				push_entry.cls = CLS_START;
				push_entry.kind = KIND_WRITE;
				push_entry.chunk = fast_q ? wr_fast_q : wr_norm_q;
			end
			FUNC_ERASE: begin
				push_entry.cls = CLS_START;
				push_entry.kind = KIND_ERASE;
				push_entry.chunk = sector_q;
			end
			FUNC_DONE:   push_entry.cls = CLS_DONE;
			FUNC_CANCEL: push_entry.cls = CLS_CANCEL;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/sfjs_queue.sv
`default_nettype none

module sfjs_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire sfjs_pkg::q_entry_t  push_entry,
	output logic                     full,
	input  wire logic                pop,
	output logic                     head_valid,
	output sfjs_pkg::q_entry_t       head
);
	import sfjs_pkg::*;

	localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int unsigned CntW = $clog2(QDepth + 1);

	q_entry_t mem_q [QDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full = (count_q == CntW'(QDepth));
	assign head_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hdl/sfjs_back.sv
`default_nettype none

module sfjs_back #(
	parameter int unsigned COMPARE_BUFFER = sfjs_pkg::COMPARE_BUFFER_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                head_valid,
	input  wire sfjs_pkg::q_entry_t  head,
	output logic                     pop,
	sfjs_rsp_if.source               rsp
);
	import sfjs_pkg::*;

	localparam logic [LenW-1:0] CmpBuf = LenW'(COMPARE_BUFFER);

	job_kind_t kind_q, kind_d;
	phase_t phase_q, phase_d;
	res_t res_q, res_d;
	logic busy_q, busy_d;
	logic [AddrW-1:0] addr_q, addr_d;
	logic [LenW-1:0] left_q, left_d;
	logic [ChunkW-1:0] chunk_q, chunk_d;
	logic [LenW-1:0] done_q, done_d;
	logic [ChunkW-1:0] pleft_q, pleft_d;

	logic o_valid_q;
	logic o_acc_q, acc_d;
	logic [CmdKindW-1:0] o_kind_q, ck_d;
	logic [7:0] o_op_q, op_d;
	logic [AddrW-1:0] o_addr_q, fa_d;
	logic [ChunkW-1:0] o_len_q, xl_d;
	logic [LenW-1:0] o_off_q, off_d;

	logic take_start;
	job_kind_t a_kind;
	logic [AddrW-1:0] a_addr;
	logic [LenW-1:0] a_left;
	logic [ChunkW-1:0] a_chunk;
	logic [LenW-1:0] a_done;
	logic [ChunkW-1:0] a_pleft;

	logic is_cmp;
	logic new_portion;
	logic [LenW-1:0] psz;
	logic [LenW-1:0] avail;
	logic [ChunkW-1:0] n;

	assign pop = head_valid && (!o_valid_q || rsp.ready);

	// A start taken while idle feeds the chunk step with its own values.
	assign take_start = (head.cls == CLS_START) && !busy_q;
	assign a_kind = take_start ? head.kind : kind_q;
	assign a_addr = take_start ? head.start_addr : addr_q;
	assign a_left = take_start ? head.length : left_q;
	assign a_chunk = take_start ? head.chunk : chunk_q;
	assign a_done = take_start ? '0 : done_q;
	assign a_pleft = take_start ? '0 : pleft_q;

	// For a compare job left_q holds the bytes beyond the current portion.
	assign is_cmp = (a_kind == KIND_CMP);
	assign new_portion = is_cmp && (a_pleft == '0);
	assign psz = (a_left < CmpBuf) ? a_left : CmpBuf;
	assign avail = new_portion ? psz : (is_cmp ? LenW'(a_pleft) : a_left);
	assign n = (avail < LenW'(a_chunk)) ? avail[ChunkW-1:0] : a_chunk;

	always_comb begin
		logic adv_en;
		logic adv_check;
		logic adv_fail;
		logic adv_ok;
		kind_d = kind_q;
		phase_d = phase_q;
		res_d = res_q;
		busy_d = busy_q;
		addr_d = addr_q;
		left_d = left_q;
		chunk_d = chunk_q;
		done_d = done_q;
		pleft_d = pleft_q;
		acc_d = 1'b0;
		ck_d = CMD_NONE;
		op_d = '0;
		fa_d = '0;
		xl_d = '0;
		off_d = '0;
		adv_en = 1'b0;
		adv_check = 1'b0;
		unique case (head.cls)
			CLS_START: begin
				if (!busy_q) begin
					acc_d = 1'b1;
					busy_d = 1'b1;
					res_d = RES_PEND;
					kind_d = head.kind;
					chunk_d = head.chunk;
					addr_d = head.start_addr;
					left_d = head.length;
					done_d = '0;
					pleft_d = '0;
					phase_d = PH_MAIN;
					adv_en = 1'b1;
				end
			end
			CLS_DONE: begin
				if (busy_q) begin
					priority if (!head.seq_ok) begin
						res_d = RES_FAIL;
						busy_d = 1'b0;
						kind_d = KIND_NONE;
						phase_d = PH_MAIN;
						pleft_d = '0;
					end else if (phase_q == PH_CMD) begin
						ck_d = CMD_RDSR;
						op_d = OPC_RDSR;
						xl_d = ChunkW'(1);
						phase_d = PH_STAT;
					end else if (phase_q == PH_STAT && head.stat_busy) begin
						ck_d = CMD_RDSR;
						op_d = OPC_RDSR;
						xl_d = ChunkW'(1);
					end else begin
						phase_d = PH_MAIN;
						adv_en = 1'b1;
						adv_check = 1'b1;
					end
				end
			end
			CLS_CANCEL: begin
				if (res_q == RES_PEND) begin
					res_d = RES_CANC;
				end
				busy_d = 1'b0;
				kind_d = KIND_NONE;
				phase_d = PH_MAIN;
				pleft_d = '0;
			end
			default: ;
		endcase

		adv_fail = new_portion && adv_check && !head.match;
		adv_ok = (new_portion || !is_cmp) && (a_left == '0);
		if (adv_en) begin
			priority if (adv_fail || adv_ok) begin
				res_d = adv_fail ? RES_FAIL : RES_OK;
				busy_d = 1'b0;
				kind_d = KIND_NONE;
				phase_d = PH_MAIN;
				pleft_d = '0;
			end else begin
				fa_d = a_addr;
				xl_d = n;
				unique case (a_kind)
					KIND_ERASE: begin
						ck_d = CMD_ERASE;
						op_d = OPC_ERASE;
					end
					KIND_WRITE: begin
						ck_d = CMD_WRITE;
						op_d = OPC_WRITE;
						off_d = a_done;
					end
					default: begin
						ck_d = CMD_READ;
						op_d = OPC_READ;
						off_d = a_done;
					end
				endcase
				addr_d = a_addr + AddrW'(n);
				done_d = a_done + LenW'(n);
				if (is_cmp) begin
					pleft_d = avail[ChunkW-1:0] - n;
					left_d = new_portion ? (a_left - psz) : a_left;
				end else begin
					left_d = a_left - LenW'(n);
				end
				phase_d = PH_CMD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_NONE;
			phase_q <= PH_MAIN;
			res_q <= RES_PEND;
			busy_q <= 1'b0;
			addr_q <= '0;
			left_q <= '0;
			chunk_q <= '0;
			done_q <= '0;
			pleft_q <= '0;
			o_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				kind_q <= kind_d;
				phase_q <= phase_d;
				res_q <= res_d;
				busy_q <= busy_d;
				addr_q <= addr_d;
				left_q <= left_d;
				chunk_q <= chunk_d;
				done_q <= done_d;
				pleft_q <= pleft_d;
				o_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			o_acc_q <= acc_d;
			o_kind_q <= ck_d;
			o_op_q <= op_d;
			o_addr_q <= fa_d;
			o_len_q <= xl_d;
			o_off_q <= off_d;
		end
	end

	assign rsp.valid = o_valid_q;
	assign rsp.accepted = o_acc_q;
	assign rsp.cmd_kind = o_kind_q;
	assign rsp.opcode = o_op_q;
	assign rsp.flash_addr = o_addr_q;
	assign rsp.xfer_len = o_len_q;
	assign rsp.buffer_offset = o_off_q;
	assign rsp.job_result = res_q;
	assign rsp.busy_res = busy_q;

	a_busy_has_kind: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (kind_q != KIND_NONE))
		else $error("Busy with no job kind.");

	a_busy_not_main: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (phase_q != PH_MAIN))
		else $error("Busy job left waiting in the main phase.");

	a_idle_no_portion: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (pleft_q == '0))
		else $error("Compare portion left over while idle.");

endmodule

`default_nettype wire

// File: hdl/spi_flash_job_sequencer_top.sv
`default_nettype none
// A result is registered in the back's output register once its item has left the queue.
// Throughput: one item per cycle while rsp.ready holds; the job state update sets that figure.
// A two-entry queue sits between the classifying front and the executing back.
// Reset (arst_n low) clears the job state, the queue count and the output valid flag at once,
// and returns the chunk registers to their reset values; no clearing pass is needed.

module spi_flash_job_sequencer_top #(
	parameter int unsigned COMPARE_BUFFER = sfjs_pkg::COMPARE_BUFFER_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	sfjs_req_if.sink req,
	sfjs_rsp_if.source rsp,
	sfjs_cfg_if.sink cfg
);
	import sfjs_pkg::*;

	logic push;
	logic full;
	logic pop;
	logic head_valid;
	q_entry_t push_entry;
	q_entry_t head;

	sfjs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg        (cfg),
		.full       (full),
		.push       (push),
		.push_entry (push_entry)
	);

	sfjs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	sfjs_back #(
		.COMPARE_BUFFER (COMPARE_BUFFER)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule

`default_nettype wire
